@@ rtl/piecewise_linear_curve_interpolator_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the curve interpolator
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CURVE_INTERPOLATOR_CORE_MACROS_SVH
`define PIECEWISE_LINEAR_CURVE_INTERPOLATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLCI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("curve interpolator check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLCI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("curve interpolator check failed");

`endif

@@ rtl/plci_pkg.sv @@
// ----------------------------------------------------------------------------
// Curve interpolator package
// Shared types, field widths and codes.
// ----------------------------------------------------------------------------
package plci_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int STEP_W    = 31;
  localparam int TOL_W     = 16;
  localparam int S_TDATA_W = 112;
  localparam int PADDR_W   = 5;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ERR_OK    = 1'b0;
  localparam logic ERR_RANGE = 1'b1;

  localparam logic [2:0] REG_EVEN  = 3'd0;
  localparam logic [2:0] REG_COUNT = 3'd1;
  localparam logic [2:0] REG_FIRST = 3'd2;
  localparam logic [2:0] REG_STEP  = 3'd3;
  localparam logic [2:0] REG_TOL   = 3'd4;

  typedef struct packed {
    logic                     even_spacing;
    logic [CNT_W-1:0]         point_count;
    logic signed [DATA_W-1:0] first_distance;
    logic [STEP_W-1:0]        distance_step;
    logic [TOL_W-1:0]         match_tolerance;
  } cfg_t;

  // Request to the scaling unit: q = floor(a * b / c), with b <= c.
  typedef struct packed {
    logic              start;
    logic [DATA_W:0]   a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
  } md_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W:0]   q;
    logic [DATA_W-1:0] rem;
  } md_rsp_t;

endpackage

@@ rtl/plci_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module plci_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/plci_regs.sv @@
// ----------------------------------------------------------------------------
// Curve interpolator configuration registers
// APB register file holding the curve settings.
// ----------------------------------------------------------------------------
module plci_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [plci_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output plci_pkg::cfg_t                 cfg
);
  import plci_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.even_spacing    <= 1'b0;
      cfg.point_count     <= '0;
      cfg.first_distance  <= '0;
      cfg.distance_step   <= STEP_W'(65536);
      cfg.match_tolerance <= TOL_W'(66);
    end else if (wr) begin
      case (idx)
        REG_EVEN:  cfg.even_spacing    <= pwdata[0];
        REG_COUNT: cfg.point_count     <= pwdata[CNT_W-1:0];
        REG_FIRST: cfg.first_distance  <= pwdata;
        REG_STEP:  cfg.distance_step   <= pwdata[STEP_W-1:0];
        REG_TOL:   cfg.match_tolerance <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EVEN:  prdata = {31'd0, cfg.even_spacing};
      REG_COUNT: prdata = {21'd0, cfg.point_count};
      REG_FIRST: prdata = cfg.first_distance;
      REG_STEP:  prdata = {1'b0, cfg.distance_step};
      REG_TOL:   prdata = {16'd0, cfg.match_tolerance};
      default:   prdata = '0;
    endcase
  end

endmodule

@@ rtl/plci_muldiv.sv @@
// ----------------------------------------------------------------------------
// Curve interpolator scaling unit
// Bit-serial floor(a*b/c) with remainder; each bit of a takes a doubling phase and an adding phase.
// ----------------------------------------------------------------------------
module plci_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  plci_pkg::md_req_t req,
  output plci_pkg::md_rsp_t rsp
);
  import plci_pkg::*;

  localparam int ABITS = DATA_W + 1;

  logic                busy;
  logic                done;
  logic                phase;
  logic [5:0]          bit_cnt;
  logic [DATA_W:0]     a_sh;
  logic [DATA_W-1:0]   b_r;
  logic [DATA_W-1:0]   c_r;
  logic [DATA_W:0]     q;
  logic [DATA_W-1:0]   r;
  logic [DATA_W:0]     dbl;
  logic [DATA_W:0]     sum;
  logic                dbl_ge;
  logic                sum_ge;
  logic [DATA_W-1:0]   dbl_next;
  logic [DATA_W-1:0]   sum_next;

  // The remainder stays below c, so each half step subtracts c at most once.
  assign dbl      = {r, 1'b0};
  assign dbl_ge   = dbl >= {1'b0, c_r};
  assign dbl_next = dbl_ge ? DATA_W'(dbl - {1'b0, c_r}) : dbl[DATA_W-1:0];
  assign sum      = {1'b0, r} + {1'b0, b_r};
  assign sum_ge   = sum >= {1'b0, c_r};
  assign sum_next = sum_ge ? DATA_W'(sum - {1'b0, c_r}) : sum[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy    <= 1'b1;
        phase   <= 1'b0;
        bit_cnt <= 6'(ABITS - 1);
        a_sh    <= req.a;
        b_r     <= req.b;
        c_r     <= req.c;
        q       <= '0;
        r       <= '0;
      end else if (busy) begin
        if (!phase) begin
          r     <= dbl_next;
          q     <= {q[DATA_W-1:0], dbl_ge};
          phase <= 1'b1;
        end else begin
          if (a_sh[DATA_W]) begin
            r <= sum_next;
            q <= q + (DATA_W+1)'(sum_ge);
          end
          a_sh  <= {a_sh[DATA_W-1:0], 1'b0};
          phase <= 1'b0;
          if (bit_cnt == 6'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            bit_cnt <= bit_cnt - 6'd1;
          end
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.q    = q;
  assign rsp.rem  = r;

endmodule

@@ rtl/piecewise_linear_curve_interpolator_core.sv @@
// A load word is written to the table in the cycle it is accepted and gives no result.
// An even-mode query answers after a divide and one table read on an exact hit,
// or after a second table read and a second divide when it interpolates.
// A query in uneven mode scans one table entry per cycle over the single read port,
// up to point_count entries, then interpolates with one divide.
// Reset is synchronous; it clears control state and the configuration registers, not the table.
// ----------------------------------------------------------------------------
// Piecewise linear curve interpolator
// Holds a time-versus-distance curve in one RAM and answers distance queries
// with linearly interpolated time in signed Q16.16.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_interpolator_core #(
  parameter int MAX_POINTS  = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [plci_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input words. tdata from bit 0 up: point_index[9:0], point_distance[41:10],
  // point_time[73:42], query_distance[105:74], zero padding.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [plci_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser from bit 0 up: operation.
  input  logic [0:0]                         s_axis_tuser,
  // Result words. tdata from bit 0 up: time_value[31:0].
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [plci_pkg::DATA_W-1:0]        m_axis_tdata,
  // tuser from bit 0 up: error_code.
  output logic [0:0]                         m_axis_tuser
);
  import plci_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = AW + 1;
  localparam int RW = DATA_W + 3;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EDIV = 3'd1;
  localparam logic [2:0] S_ERD0 = 3'd2;
  localparam logic [2:0] S_ERD1 = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_LERP = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  // Clamp to the signed VALUE_WIDTH range and keep the low 32 bits.
  function automatic logic [DATA_W-1:0] saturate(input logic signed [RW-1:0] v);
    logic signed [49:0] vw;
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    vw = 50'(v);
    hi = (50'sd1 <<< (VALUE_WIDTH - 1)) - 50'sd1;
    lo = -hi - 50'sd1;
    if (vw > hi) begin
      vw = hi;
    end else if (vw < lo) begin
      vw = lo;
    end
    return vw[DATA_W-1:0];
  endfunction

  cfg_t    cfg;
  md_req_t md_req;
  md_rsp_t md_rsp;

  logic [2:0]               state;
  logic                     acc;
  logic                     op;
  logic [IDX_W-1:0]         pidx;
  logic signed [DATA_W-1:0] pdist;
  logic signed [DATA_W-1:0] ptime;
  logic signed [DATA_W-1:0] qdist;
  logic [CW-1:0]            cnt;
  logic [DATA_W-1:0]        step;
  logic [DATA_W-1:0]        tol;

  // Table: each RAM word holds a point's time in the upper half and distance below.
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [2*DATA_W-1:0]      mem_rdata;
  logic signed [DATA_W-1:0] cur_x;
  logic signed [DATA_W-1:0] cur_y;

  logic signed [DATA_W-1:0] d_r;
  logic [CW-1:0]            n_r;
  logic [DATA_W-1:0]        rem_r;
  logic signed [DATA_W-1:0] y0_r;
  logic signed [DATA_W-1:0] prev_x;
  logic signed [DATA_W-1:0] prev_y;
  logic                     diff_neg;
  logic signed [RW-1:0]     res_r;
  logic                     err_r;
  logic [CW-1:0]            iss;
  logic [CW-1:0]            chk;
  logic                     out_valid;
  logic [DATA_W-1:0]        out_data;
  logic                     out_err;

  logic signed [DATA_W:0]   t_even;
  logic signed [DATA_W:0]   diff_e;
  logic signed [DATA_W:0]   diff_u;
  logic signed [DATA_W+1:0] gap;
  logic                     tol_hit;
  logic                     bracket;
  logic [RW-1:0]            q_ext;
  logic [RW-1:0]            s_val;

  plci_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  plci_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({ptime, pdist}),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  plci_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Input word fields.
  assign op    = s_axis_tuser[0];
  assign pidx  = s_axis_tdata[9:0];
  assign pdist = s_axis_tdata[41:10];
  assign ptime = s_axis_tdata[73:42];
  assign qdist = s_axis_tdata[105:74];

  // The block takes one word at a time; the output register lets the next word
  // in while a result still waits downstream.
  assign s_axis_tready = (state == S_IDLE);
  assign acc           = s_axis_tvalid & s_axis_tready;

  // Points in use, limited to the table depth; a zero step acts as one.
  assign cnt  = ({6'd0, cfg.point_count} > 17'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                           : CW'(cfg.point_count);
  assign step = (cfg.distance_step == '0) ? DATA_W'(1) : {1'b0, cfg.distance_step};
  assign tol  = {16'd0, cfg.match_tolerance};

  // A load to a slot beyond the table depth is dropped.
  assign mem_we    = acc && (op == OP_LOAD) && (17'(pidx) < 17'(MAX_POINTS));
  assign mem_waddr = AW'(pidx);

  assign cur_x = mem_rdata[DATA_W-1:0];
  assign cur_y = mem_rdata[2*DATA_W-1:DATA_W];

  assign t_even = {qdist[DATA_W-1], qdist} - {cfg.first_distance[DATA_W-1], cfg.first_distance};
  assign diff_e = {cur_y[DATA_W-1], cur_y} - {y0_r[DATA_W-1], y0_r};
  assign diff_u = {cur_y[DATA_W-1], cur_y} - {prev_y[DATA_W-1], prev_y};

  // Scan checks: the segment from the previous point takes priority over an
  // exact hit on the current one, since the previous point's own hit already failed.
  assign gap     = (DATA_W+2)'(cur_x) - (DATA_W+2)'(d_r);
  assign tol_hit = (gap < $signed({2'b00, tol})) && (gap > -$signed({2'b00, tol}));
  assign bracket = (chk != '0) && (prev_x <= d_r) && (cur_x > d_r);

  // Rounding toward minus infinity: a negative slope takes -q, one lower if inexact.
  assign q_ext = RW'(md_rsp.q);
  assign s_val = diff_neg ? (~q_ext + RW'(md_rsp.rem == '0)) : q_ext;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        mem_re    = acc && (op == OP_QUERY) && !cfg.even_spacing;
        mem_raddr = '0;
      end
      S_EDIV: begin
        mem_re    = md_rsp.done;
        mem_raddr = md_rsp.q[AW-1:0];
      end
      S_ERD0: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(n_r + CW'(1));
      end
      S_SCAN: begin
        mem_re    = iss < cnt;
        mem_raddr = iss[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      md_req.start <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      md_req.start <= 1'b0;
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc && (op == OP_QUERY)) begin
            d_r   <= qdist;
            err_r <= ERR_OK;
            if (cnt == '0) begin
              err_r <= ERR_RANGE;
              state <= S_FIN;
            end else if (cfg.even_spacing) begin
              if (t_even[DATA_W]) begin
                err_r <= ERR_RANGE;
                state <= S_FIN;
              end else begin
                md_req.start <= 1'b1;
                md_req.a     <= t_even;
                md_req.b     <= DATA_W'(1);
                md_req.c     <= step;
                state        <= S_EDIV;
              end
            end else begin
              iss   <= CW'(1);
              chk   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_EDIV: begin
          if (md_rsp.done) begin
            if (md_rsp.q >= (DATA_W+1)'(cnt)) begin
              err_r <= ERR_RANGE;
              state <= S_FIN;
            end else begin
              n_r   <= CW'(md_rsp.q);
              rem_r <= md_rsp.rem;
              state <= S_ERD0;
            end
          end
        end
        S_ERD0: begin
          if (rem_r < tol) begin
            res_r <= RW'(cur_y);
            state <= S_FIN;
          end else if ((n_r + CW'(1)) >= cnt) begin
            err_r <= ERR_RANGE;
            state <= S_FIN;
          end else begin
            y0_r  <= cur_y;
            state <= S_ERD1;
          end
        end
        S_ERD1: begin
          md_req.start <= 1'b1;
          md_req.a     <= diff_e[DATA_W] ? -diff_e : diff_e;
          md_req.b     <= rem_r;
          md_req.c     <= step;
          diff_neg     <= diff_e[DATA_W];
          state        <= S_LERP;
        end
        S_SCAN: begin
          if (iss < cnt) begin
            iss <= iss + CW'(1);
          end
          if (bracket) begin
            y0_r         <= prev_y;
            md_req.start <= 1'b1;
            md_req.a     <= diff_u[DATA_W] ? -diff_u : diff_u;
            md_req.b     <= DATA_W'(d_r - prev_x);
            md_req.c     <= DATA_W'(cur_x - prev_x);
            diff_neg     <= diff_u[DATA_W];
            state        <= S_LERP;
          end else if (tol_hit) begin
            res_r <= RW'(cur_y);
            state <= S_FIN;
          end else if (chk == cnt - CW'(1)) begin
            err_r <= ERR_RANGE;
            state <= S_FIN;
          end else begin
            prev_x <= cur_x;
            prev_y <= cur_y;
            chk    <= chk + CW'(1);
          end
        end
        S_LERP: begin
          if (md_rsp.done) begin
            res_r <= s_val;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          res_r <= res_r + RW'(y0_r);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || m_axis_tready) begin
            out_valid <= 1'b1;
            out_err   <= err_r;
            out_data  <= (err_r == ERR_RANGE) ? '0 : saturate(res_r);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_err;

  `include "piecewise_linear_curve_interpolator_core_macros.svh"

  // The scaling unit is only started when it is free.
  `PLCI_ASSERT_SAME(a_md_start_free, md_req.start, !md_rsp.busy)
  // A finished result never overwrites one still waiting downstream.
  `PLCI_ASSERT_NEXT(a_fin_waits, (state == S_FIN) && m_axis_tvalid && !m_axis_tready, state == S_FIN)
  // An error result carries zero time.
  `PLCI_ASSERT_SAME(a_err_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)

endmodule
